[rtl/core/tct_pkg.sv]
`timescale 1ns / 1ps

package tct_pkg;

	localparam int unsigned POS_W = 6;
	localparam int unsigned ARG_W = 8;

	typedef enum logic [3:0] {
		REQ_MOVE_TO     = 4'd0,
		REQ_UP          = 4'd1,
		REQ_DOWN        = 4'd2,
		REQ_FORWARD     = 4'd3,
		REQ_BACK        = 4'd4,
		REQ_LF          = 4'd5,
		REQ_REVERSE_LF  = 4'd6,
		REQ_ADVANCE     = 4'd7,
		REQ_SAVE        = 4'd8,
		REQ_RESTORE     = 4'd9,
		REQ_GLYPH_DRAWN = 4'd10,
		REQ_HOME        = 4'd11
	} req_code_t;

	typedef struct packed {
		logic [3:0]       req_type;
		logic [ARG_W-1:0] row_arg;
		logic [ARG_W-1:0] col_arg;
		logic [ARG_W-1:0] step_count;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0] cursor_col;
		logic [POS_W-1:0] cursor_row;
		logic             wrapped_flag;
		logic             scroll_up_req;
		logic             scroll_down_req;
	} res_t;

	// handshake between the input stage and the result stage
	typedef struct packed {
		logic cmd_valid;
		logic res_take;
	} stage_ctl_t;

endpackage

[rtl/core/terminal_cursor_tracker_core.sv]
`timescale 1ns / 1ps

// Terminal cursor tracker.
// Input channel (in_valid/in_ready): one command beat carries req_type, row_arg,
// col_arg and step_count. Output channel (out_valid/out_ready): one result beat
// per command with the cursor position, the wrapped flag and one-beat scroll
// requests for the display.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes wrap_enable; always
// ready, and should only be written while no command is in flight.
// An accepted command passes the input register, then the result register,
// before its result reaches the output.
// Throughput: one command per cycle while out_ready is high; cursor state updates
// as a command moves from input to result register, so the next command sees it.
// Reset (arst_n low): cursor, saved cursor and wrapped flag go to zero,
// wrap_enable goes to one, both pipeline registers empty.
// Receiver stall: the result register holds; the input register holds one more
// command, after which in_ready drops until out_ready returns.
module terminal_cursor_tracker_core #(
	parameter int unsigned TEXT_COLUMNS  = 40,
	parameter int unsigned VISIBLE_LINES = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] req_type,
	input  logic [7:0] row_arg,
	input  logic [7:0] col_arg,
	input  logic [7:0] step_count,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] cursor_col,
	output logic [5:0] cursor_row,
	output logic       wrapped_flag,
	output logic       scroll_up_req,
	output logic       scroll_down_req
);
	import tct_pkg::*;

	cmd_t       cmd_in, cmd_s1;
	logic       cmd_valid_s1;
	logic       res_take;
	res_t       res_next, res_s2;
	stage_ctl_t ctl;

	assign cfg_ready = 1'b1;

	assign cmd_in.req_type   = req_type;
	assign cmd_in.row_arg    = row_arg;
	assign cmd_in.col_arg    = col_arg;
	assign cmd_in.step_count = step_count;

	assign ctl.cmd_valid = cmd_valid_s1;
	assign ctl.res_take  = res_take;

	tct_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd_in       (cmd_in),
		.res_take     (res_take),
		.cmd_s1       (cmd_s1),
		.cmd_valid_s1 (cmd_valid_s1)
	);

	tct_cursor_engine #(
		.TEXT_COLUMNS  (TEXT_COLUMNS),
		.VISIBLE_LINES (VISIBLE_LINES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_wrap (cfg_data),
		.ctl      (ctl),
		.cmd_s1   (cmd_s1),
		.res      (res_next)
	);

	tct_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid_s1 (cmd_valid_s1),
		.res_in       (res_next),
		.res_take     (res_take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res_s2       (res_s2)
	);

	assign cursor_col      = res_s2.cursor_col;
	assign cursor_row      = res_s2.cursor_row;
	assign wrapped_flag    = res_s2.wrapped_flag;
	assign scroll_up_req   = res_s2.scroll_up_req;
	assign scroll_down_req = res_s2.scroll_down_req;

endmodule

[rtl/core/tct_in_stage.sv]
`timescale 1ns / 1ps

module tct_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tct_pkg::cmd_t     cmd_in,
	input  logic              res_take,
	output tct_pkg::cmd_t     cmd_s1,
	output logic              cmd_valid_s1
);
	import tct_pkg::*;

	logic advance;

	// the held command moves on whenever the result register can take it
	assign advance  = cmd_valid_s1 && res_take;
	assign in_ready = !cmd_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			cmd_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

[rtl/core/tct_cursor_engine.sv]
`timescale 1ns / 1ps

module tct_cursor_engine #(
	parameter int unsigned TEXT_COLUMNS  = 40,
	parameter int unsigned VISIBLE_LINES = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wrap,
	input  tct_pkg::stage_ctl_t  ctl,
	input  tct_pkg::cmd_t        cmd_s1,
	output tct_pkg::res_t        res
);
	import tct_pkg::*;

	localparam logic [POS_W-1:0] LAST_COL = POS_W'(TEXT_COLUMNS - 1);
	localparam logic [POS_W-1:0] LAST_ROW = POS_W'(VISIBLE_LINES - 1);
	localparam logic [ARG_W:0]   LAST_COL_W = (ARG_W+1)'(TEXT_COLUMNS - 1);
	localparam logic [ARG_W:0]   LAST_ROW_W = (ARG_W+1)'(VISIBLE_LINES - 1);
	localparam logic [POS_W:0]   COLS_W = (POS_W+1)'(TEXT_COLUMNS);
	localparam logic [ARG_W-1:0] COLS_A = ARG_W'(TEXT_COLUMNS);
	localparam logic [ARG_W-1:0] ROWS_A = ARG_W'(VISIBLE_LINES);

	logic             wrap_q;
	logic [POS_W-1:0] col_q, row_q, saved_col_q, saved_row_q;
	logic             jw_q;

	logic [POS_W-1:0] col_d, row_d, saved_col_d, saved_row_d;
	logic             jw_d, sc_up, sc_down;
	logic             fire;

	logic [ARG_W:0]   step_n;
	logic [ARG_W-1:0] row_tgt, col_tgt;
	logic [ARG_W:0]   row_sum, col_sum;
	logic [POS_W:0]   col_inc;

	assign fire = ctl.cmd_valid && ctl.res_take;

	assign step_n  = (cmd_s1.step_count == '0) ? (ARG_W+1)'(1) : {1'b0, cmd_s1.step_count};
	assign row_tgt = (cmd_s1.row_arg == '0) ? '0 : cmd_s1.row_arg - ARG_W'(1);
	assign col_tgt = (cmd_s1.col_arg == '0) ? '0 : cmd_s1.col_arg - ARG_W'(1);
	assign row_sum = (ARG_W+1)'(row_q) + step_n;
	assign col_sum = (ARG_W+1)'(col_q) + step_n;
	assign col_inc = {1'b0, col_q} + (POS_W+1)'(1);

	always_comb begin
		col_d       = col_q;
		row_d       = row_q;
		jw_d        = jw_q;
		saved_col_d = saved_col_q;
		saved_row_d = saved_row_q;
		sc_up       = 1'b0;
		sc_down     = 1'b0;
		case (req_code_t'(cmd_s1.req_type))
			REQ_MOVE_TO: begin
				row_d = ({1'b0, row_tgt} > LAST_ROW_W) ? LAST_ROW : row_tgt[POS_W-1:0];
				col_d = ({1'b0, col_tgt} > LAST_COL_W) ? LAST_COL : col_tgt[POS_W-1:0];
			end
			REQ_UP: begin
				row_d = (step_n > (ARG_W+1)'(row_q)) ? '0 : row_q - step_n[POS_W-1:0];
			end
			REQ_DOWN: begin
				row_d = (row_sum > LAST_ROW_W) ? LAST_ROW : row_sum[POS_W-1:0];
			end
			REQ_FORWARD: begin
				col_d = (col_sum > LAST_COL_W) ? LAST_COL : col_sum[POS_W-1:0];
			end
			REQ_BACK: begin
				col_d = (step_n > (ARG_W+1)'(col_q)) ? '0 : col_q - step_n[POS_W-1:0];
			end
			REQ_LF: begin
				// first line feed after a wrap is swallowed, unless a glyph was drawn in between
				if (wrap_q && jw_q) begin
					jw_d = 1'b0;
				end else if (row_q >= LAST_ROW) begin
					row_d = LAST_ROW;
					sc_up = 1'b1;
				end else begin
					row_d = row_q + POS_W'(1);
				end
			end
			REQ_REVERSE_LF: begin
				if (row_q != '0) begin
					row_d = ((row_q - POS_W'(1)) > LAST_ROW) ? LAST_ROW : row_q - POS_W'(1);
					col_d = (col_q > LAST_COL) ? LAST_COL : col_q;
				end else begin
					sc_down = 1'b1;
				end
			end
			REQ_ADVANCE: begin
				if (col_inc >= COLS_W) begin
					if (wrap_q) begin
						col_d = '0;
						jw_d  = 1'b1;
						if (row_q >= LAST_ROW) begin
							row_d = LAST_ROW;
							sc_up = 1'b1;
						end else begin
							row_d = row_q + POS_W'(1);
						end
					end else begin
						col_d = LAST_COL;
					end
				end else begin
					col_d = col_inc[POS_W-1:0];
				end
			end
			REQ_SAVE: begin
				saved_col_d = col_q;
				saved_row_d = row_q;
			end
			REQ_RESTORE: begin
				col_d = saved_col_q;
				row_d = saved_row_q;
			end
			REQ_GLYPH_DRAWN: begin
				if (cmd_s1.row_arg < ROWS_A && cmd_s1.col_arg < COLS_A) begin
					jw_d = 1'b0;
				end
			end
			REQ_HOME: begin
				col_d = '0;
				row_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q      <= 1'b1;
			col_q       <= '0;
			row_q       <= '0;
			jw_q        <= 1'b0;
			saved_col_q <= '0;
			saved_row_q <= '0;
		end else begin
			if (cfg_we) begin
				wrap_q <= cfg_wrap;
			end
			if (fire) begin
				col_q       <= col_d;
				row_q       <= row_d;
				jw_q        <= jw_d;
				saved_col_q <= saved_col_d;
				saved_row_q <= saved_row_d;
			end
		end
	end

	assign res.cursor_col      = col_d;
	assign res.cursor_row      = row_d;
	assign res.wrapped_flag    = jw_d;
	assign res.scroll_up_req   = sc_up;
	assign res.scroll_down_req = sc_down;

endmodule

[rtl/core/tct_out_stage.sv]
`timescale 1ns / 1ps

module tct_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid_s1,
	input  tct_pkg::res_t     res_in,
	output logic              res_take,
	output logic              out_valid,
	input  logic              out_ready,
	output tct_pkg::res_t     res_s2
);
	import tct_pkg::*;

	// free when empty or when the current beat leaves this cycle
	assign res_take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_take) begin
			out_valid <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && cmd_valid_s1) begin
			res_s2 <= res_in;
		end
	end

endmodule

[rtl/core/tct_checker.sv]
`timescale 1ns / 1ps

module tct_checker #(
	parameter int unsigned TEXT_COLUMNS  = 40,
	parameter int unsigned VISIBLE_LINES = 30
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] cursor_col,
	input logic [5:0] cursor_row,
	input logic       wrapped_flag,
	input logic       scroll_up_req,
	input logic       scroll_down_req
);
	localparam logic [6:0] COLS = 7'(TEXT_COLUMNS);
	localparam logic [6:0] ROWS = 7'(VISIBLE_LINES);
	localparam logic [5:0] LAST_ROW = 6'(VISIBLE_LINES - 1);

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, cursor_col} < COLS) && ({1'b0, cursor_row} < ROWS))
		else $error("cursor outside the screen");

	a_scroll_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(scroll_up_req && scroll_down_req))
		else $error("scroll up and down in one beat");

	a_scroll_up_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scroll_up_req |-> cursor_row == LAST_ROW)
		else $error("scroll up away from the bottom row");

	a_scroll_down_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scroll_down_req |-> cursor_row == 6'd0 && !scroll_up_req)
		else $error("scroll down away from the top row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_col)
			&& $stable(cursor_row) && $stable(wrapped_flag))
		else $error("result beat changed while stalled");

endmodule

bind terminal_cursor_tracker_core tct_checker #(
	.TEXT_COLUMNS  (TEXT_COLUMNS),
	.VISIBLE_LINES (VISIBLE_LINES)
) u_tct_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.cursor_col      (cursor_col),
	.cursor_row      (cursor_row),
	.wrapped_flag    (wrapped_flag),
	.scroll_up_req   (scroll_up_req),
	.scroll_down_req (scroll_down_req)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tct_pkg::*;

	localparam int unsigned COLS = 40;
	localparam int unsigned ROWS = 30;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned LONG_HOLD = 60;
	localparam int unsigned PHASE_ITEMS = 80;
	localparam int unsigned PHASES = 8;
	localparam int unsigned MAX_PRINTS = 40;
	localparam logic [3:0] REQ_SPARE_LO = 4'd12;
	localparam logic [3:0] REQ_SPARE_HI = 4'd15;

	typedef struct {
		cmd_t cmd;
		bit   fixed;
		res_t want;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] req_type = '0;
	logic [7:0] row_arg = '0;
	logic [7:0] col_arg = '0;
	logic [7:0] step_count = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [5:0] cursor_col;
	logic [5:0] cursor_row;
	logic       wrapped_flag;
	logic       scroll_up_req;
	logic       scroll_down_req;

	// predicted cursor state
	logic [POS_W-1:0] trk_col, trk_row, trk_save_col, trk_save_row;
	logic             trk_wrapped, trk_wrap_en;

	res_t        cursor_due[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned tx_idle_pct = 0;

	always #10 clk = ~clk;

	terminal_cursor_tracker_core #(
		.TEXT_COLUMNS(COLS),
		.VISIBLE_LINES(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.row_arg(row_arg),
		.col_arg(col_arg),
		.step_count(step_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.wrapped_flag(wrapped_flag),
		.scroll_up_req(scroll_up_req),
		.scroll_down_req(scroll_down_req)
	);

	function automatic void reset_tracker();
		trk_col = '0;
		trk_row = '0;
		trk_save_col = '0;
		trk_save_row = '0;
		trk_wrapped = 1'b0;
		trk_wrap_en = 1'b1;
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input int unsigned v, input int unsigned last);
		return (v > last) ? POS_W'(last) : POS_W'(v);
	endfunction

	// bottom row: cursor stays, display scrolls up instead
	function automatic logic line_down();
		if (trk_row >= ROWS - 1) begin
			trk_row = POS_W'(ROWS - 1);
			return 1'b1;
		end
		trk_row = trk_row + 1'b1;
		return 1'b0;
	endfunction

	function automatic res_t track_cursor(input cmd_t c);
		res_t        r;
		int unsigned hop;
		r = '0;
		hop = (c.step_count == 0) ? 1 : c.step_count;
		case (c.req_type)
			REQ_MOVE_TO: begin
				trk_row = clamp_pos((c.row_arg == 0) ? 0 : c.row_arg - 1, ROWS - 1);
				trk_col = clamp_pos((c.col_arg == 0) ? 0 : c.col_arg - 1, COLS - 1);
			end
			REQ_UP: trk_row = (hop > trk_row) ? '0 : POS_W'(trk_row - hop);
			REQ_DOWN: trk_row = clamp_pos(trk_row + hop, ROWS - 1);
			REQ_FORWARD: trk_col = clamp_pos(trk_col + hop, COLS - 1);
			REQ_BACK: trk_col = (hop > trk_col) ? '0 : POS_W'(trk_col - hop);
			REQ_LF: begin
				// first line feed after a wrap is swallowed, unless a glyph was drawn in between
				if (trk_wrap_en && trk_wrapped)
					trk_wrapped = 1'b0;
				else
					r.scroll_up_req = line_down();
			end
			REQ_REVERSE_LF: begin
				if (trk_row > 0)
					trk_row = trk_row - 1'b1;
				else
					r.scroll_down_req = 1'b1;
			end
			REQ_ADVANCE: begin
				if (trk_col + 1 >= COLS) begin
					if (trk_wrap_en) begin
						trk_col = '0;
						r.scroll_up_req = line_down();
						trk_wrapped = 1'b1;
					end else begin
						trk_col = POS_W'(COLS - 1);
					end
				end else begin
					trk_col = trk_col + 1'b1;
				end
			end
			REQ_SAVE: begin
				trk_save_col = trk_col;
				trk_save_row = trk_row;
			end
			REQ_RESTORE: begin
				trk_col = trk_save_col;
				trk_row = trk_save_row;
			end
			REQ_GLYPH_DRAWN: begin
				if (c.row_arg < ROWS && c.col_arg < COLS)
					trk_wrapped = 1'b0;
			end
			REQ_HOME: begin
				trk_col = '0;
				trk_row = '0;
			end
			default: ;
		endcase
		r.cursor_col = trk_col;
		r.cursor_row = trk_row;
		r.wrapped_flag = trk_wrapped;
		return r;
	endfunction

	function automatic script_row_t make_row(input logic [3:0] req, input logic [7:0] ra,
			input logic [7:0] ca, input logic [7:0] sc, input bit fixed,
			input logic [5:0] col, input logic [5:0] row, input logic w,
			input logic su, input logic sd);
		script_row_t s;
		s.cmd = '{req_type: req, row_arg: ra, col_arg: ca, step_count: sc};
		s.fixed = fixed;
		s.want = '{cursor_col: col, cursor_row: row, wrapped_flag: w,
			scroll_up_req: su, scroll_down_req: sd};
		return s;
	endfunction

	// mostly near the screen edge, where clamping and range checks flip
	function automatic logic [7:0] pick_arg(input int unsigned size);
		case ($urandom_range(3))
			0: return 8'($urandom_range(255));
			1: return 8'($urandom_range(size));
			2: return 8'($urandom_range(size + 2, size - 2));
			default: return 8'($urandom_range(2));
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 4)
			c.req_type = 4'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
		else if (pick < 26)
			c.req_type = REQ_ADVANCE;
		else if (pick < 36)
			c.req_type = REQ_LF;
		else
			c.req_type = 4'($urandom_range(REQ_HOME, REQ_MOVE_TO));
		c.row_arg = pick_arg(ROWS);
		c.col_arg = pick_arg(COLS);
		case ($urandom_range(2))
			0: c.step_count = 8'($urandom_range(255));
			1: c.step_count = 8'($urandom_range(3));
			default: c.step_count = 8'($urandom_range(45, 25));
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic send_cmd(input cmd_t c, input bit fixed, input res_t want);
		res_t predicted;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= c.req_type;
		row_arg <= c.row_arg;
		col_arg <= c.col_arg;
		step_count <= c.step_count;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = track_cursor(c);
		cursor_due.push_back(fixed ? want : predicted);
	endtask

	task automatic write_wrap(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		trk_wrap_en = v;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cursor_due.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cursor_due.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				want = cursor_due.pop_front();
				check_field("cursor_col", cursor_col, want.cursor_col);
				check_field("cursor_row", cursor_row, want.cursor_row);
				check_field("wrapped_flag", wrapped_flag, want.wrapped_flag);
				check_field("scroll_up_req", scroll_up_req, want.scroll_up_req);
				check_field("scroll_down_req", scroll_down_req, want.scroll_down_req);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin : stimulus
		script_row_t script[$];
		int unsigned mode;
		reset_tracker();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrap enabled out of reset
		script.push_back(make_row(REQ_SAVE, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_REVERSE_LF, 0, 0, 0, 1, 0, 0, 0, 0, 1));
		script.push_back(make_row(REQ_MOVE_TO, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_MOVE_TO, 255, 255, 0, 1, 39, 29, 0, 0, 0));
		script.push_back(make_row(REQ_LF, 0, 0, 0, 1, 39, 29, 0, 1, 0));
		script.push_back(make_row(REQ_ADVANCE, 0, 0, 0, 1, 0, 29, 1, 1, 0));
		script.push_back(make_row(REQ_LF, 0, 0, 0, 1, 0, 29, 0, 0, 0));
		script.push_back(make_row(REQ_UP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_UP, 0, 0, 255, 1, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_DOWN, 0, 0, 255, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_FORWARD, 0, 0, 255, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_BACK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_GLYPH_DRAWN, 30, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_GLYPH_DRAWN, 0, 40, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_GLYPH_DRAWN, 29, 39, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_BACK, 0, 0, 255, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_RESTORE, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_MOVE_TO, 12, 1, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_REVERSE_LF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_HOME, 255, 255, 255, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_SPARE_LO, 255, 255, 255, 0, 0, 0, 0, 0, 0));
		script.push_back(make_row(REQ_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		foreach (script[i])
			send_cmd(script[i].cmd, script[i].fixed, script[i].want);
		drain();

		for (int unsigned p = 0; p < PHASES; p++) begin
			write_wrap(p[0]);
			mode = p % 4;
			tx_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 26 : 0;
			rx_stall_pct <= (mode == 2) ? 51 : (mode == 3) ? 26 : 0;
			// long receiver hold while beats keep coming, to back up the pipe
			if (p == 0)
				hold_req <= hold_req + 1;
			for (int unsigned k = 0; k < PHASE_ITEMS; k++)
				send_cmd(random_cmd(), 1'b0, '0);
			drain();
		end

		repeat (4)
			@(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
